[hdl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared sizes, header layout, memory request and sequencer states of the
// first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

	// heap geometry
	localparam int HEAP_SIZE    = 4096;
	localparam int HDR_BYTES    = 8;
	localparam int ADDR_W       = $clog2(HEAP_SIZE);
	localparam int SIZE_W       = ADDR_W;

	// transaction field widths
	localparam int REQ_W        = 13;
	localparam int OFF_W        = 12;

	// working width for offset sums and compares
	localparam int NXT_A        = ADDR_W + 2;
	localparam int NXT_B        = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 1;
	localparam int NXT_W        = (NXT_A > NXT_B) ? NXT_A : NXT_B;

	// request kinds
	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// one header entry
	typedef struct packed {
		logic              free;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	localparam hdr_t HDR_RESET = '{free: 1'b1, size: SIZE_W'(HEAP_SIZE - HDR_BYTES)};

	// header memory access, one per cycle
	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		hdr_t              wdata;
	} mem_req_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_RD,
		ST_A_CHK,
		ST_A_WR1,
		ST_A_WR2,
		ST_R_RD,
		ST_R_MOD,
		ST_M_RDA,
		ST_M_LDA,
		ST_M_RDB,
		ST_M_CHK,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

[hdl/ffha_req_if.sv]
// ----------------------------------------------------------------------------
// ffha_req_if
// Request channel: allocate or release transaction with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_req_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [ffha_pkg::REQ_W-1:0] request_size;
	logic [ffha_pkg::OFF_W-1:0] release_offset;

	modport source (output valid, output kind, output request_size,
		output release_offset, input ready);
	modport sink (input valid, input kind, input request_size,
		input release_offset, output ready);
endinterface

`default_nettype wire

[hdl/ffha_rsp_if.sv]
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Result channel: grant flag and payload offset with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       granted;
	logic [ffha_pkg::OFF_W-1:0] payload_offset;

	modport source (output valid, output granted, output payload_offset,
		input ready);
	modport sink (input valid, input granted, input payload_offset,
		output ready);
endinterface

`default_nettype wire

[hdl/ffha_hdr_ram.sv]
// ----------------------------------------------------------------------------
// ffha_hdr_ram
// Single-port header store, one entry per heap byte offset, registered read.
// Entry zero reads as the initial free block until it is first written.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_hdr_ram (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire ffha_pkg::mem_req_t   mem_req,
	output ffha_pkg::hdr_t            rd_data
);

	ffha_pkg::hdr_t mem [ffha_pkg::HEAP_SIZE];
	ffha_pkg::hdr_t rd_q;
	logic           zero_init_q;
	logic           zero_sel_q;

	// storage array, write or read each cycle that the request is enabled
	always_ff @(posedge clk) begin
		if (mem_req.en) begin
			if (mem_req.we) begin
				mem[mem_req.addr] <= mem_req.wdata;
			end else begin
				rd_q <= mem[mem_req.addr];
			end
		end
	end

	// track first write of entry zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_init_q <= 1'b0;
			zero_sel_q  <= 1'b0;
		end else if (mem_req.en) begin
			if (mem_req.we) begin
				if (mem_req.addr == '0) begin
					zero_init_q <= 1'b1;
				end
			end else begin
				zero_sel_q <= (mem_req.addr == '0) && !zero_init_q;
			end
		end
	end

	// overlay reset header on unwritten entry zero
	assign rd_data = zero_sel_q ? ffha_pkg::HDR_RESET : rd_q;

endmodule

`default_nettype wire

[hdl/ffha_ctrl.sv]
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer and datapath: walks the header chain for allocation, splits
// blocks, and runs the merge sweep after a release. Holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	ffha_req_if.sink                  req,
	ffha_rsp_if.source                rsp,
	output ffha_pkg::mem_req_t        mem_req,
	input  wire ffha_pkg::hdr_t       rd_data
);

	localparam int                NW     = ffha_pkg::NXT_W;
	localparam int                AW     = ffha_pkg::ADDR_W;
	localparam int                SW     = ffha_pkg::SIZE_W;
	localparam int                OW     = ffha_pkg::OFF_W;
	localparam logic [NW-1:0]     HDR_N  = NW'(ffha_pkg::HDR_BYTES);
	localparam logic [NW-1:0]     HEAP_N = NW'(ffha_pkg::HEAP_SIZE);

	ffha_pkg::state_t             state_q, state_d;

	logic [AW-1:0]                h_q;
	logic [AW-1:0]                b_q;
	logic [AW-1:0]                r_q;
	logic [ffha_pkg::REQ_W-1:0]   want_q;
	logic [SW-1:0]                asize_q;
	logic                         afree_q;
	logic [SW-1:0]                wsize_q;
	logic [SW-1:0]                rest_q;
	logic                         split_q;
	logic                         r_ok_q;
	logic                         res_granted_q;
	logic [OW-1:0]                res_off_q;
	logic                         out_valid_q;
	logic                         out_granted_q;
	logic [OW-1:0]                out_off_q;

	logic                         accept;
	logic                         out_free;
	logic [NW-1:0]                rel_h;
	logic                         rel_bad;
	logic                         fit;
	logic [NW-1:0]                diff;
	logic                         split;
	logic [NW-1:0]                r_sum;
	logic [NW-1:0]                merged;
	logic                         do_merge;
	logic [AW-1:0]                nx_base;
	logic [SW-1:0]                nx_size;
	logic [NW-1:0]                nxt;
	logic                         nx_end;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	// release offset check
	assign rel_h   = NW'(req.release_offset) - HDR_N;
	assign rel_bad = (NW'(req.release_offset) < HDR_N) || (rel_h >= HEAP_N);

	// fit test and split arithmetic on the header just read
	assign fit   = rd_data.free && (NW'(rd_data.size) >= NW'(want_q));
	assign diff  = NW'(rd_data.size) - NW'(want_q);
	assign split = diff >= HDR_N;
	assign r_sum = NW'(h_q) + HDR_N + NW'(want_q);

	// merge of two adjacent free blocks
	assign merged   = NW'(asize_q) + NW'(rd_data.size) + HDR_N;
	assign do_merge = afree_q && rd_data.free;

	// next header offset along the chain
	always_comb begin
		nx_base = h_q;
		nx_size = rd_data.size;
		if (state_q == ffha_pkg::ST_M_CHK) begin
			if (do_merge) begin
				nx_base = h_q;
				nx_size = SW'(merged);
			end else begin
				nx_base = b_q;
			end
		end
	end

	assign nxt    = NW'(nx_base) + HDR_N + NW'(nx_size);
	assign nx_end = nxt >= HEAP_N;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffha_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (req.kind == ffha_pkg::KIND_RELEASE) begin
						state_d = rel_bad ? ffha_pkg::ST_DONE : ffha_pkg::ST_R_RD;
					end else begin
						state_d = ffha_pkg::ST_A_RD;
					end
				end
			end
			ffha_pkg::ST_A_RD:  state_d = ffha_pkg::ST_A_CHK;
			ffha_pkg::ST_A_CHK: begin
				if (fit) begin
					state_d = ffha_pkg::ST_A_WR1;
				end else begin
					state_d = nx_end ? ffha_pkg::ST_DONE : ffha_pkg::ST_A_RD;
				end
			end
			ffha_pkg::ST_A_WR1: begin
				state_d = (split_q && r_ok_q) ? ffha_pkg::ST_A_WR2 : ffha_pkg::ST_DONE;
			end
			ffha_pkg::ST_A_WR2: state_d = ffha_pkg::ST_DONE;
			ffha_pkg::ST_R_RD:  state_d = ffha_pkg::ST_R_MOD;
			ffha_pkg::ST_R_MOD: state_d = ffha_pkg::ST_M_RDA;
			ffha_pkg::ST_M_RDA: state_d = ffha_pkg::ST_M_LDA;
			ffha_pkg::ST_M_LDA: state_d = nx_end ? ffha_pkg::ST_DONE : ffha_pkg::ST_M_RDB;
			ffha_pkg::ST_M_RDB: state_d = ffha_pkg::ST_M_CHK;
			ffha_pkg::ST_M_CHK: state_d = nx_end ? ffha_pkg::ST_DONE : ffha_pkg::ST_M_RDB;
			ffha_pkg::ST_DONE:  state_d = out_free ? ffha_pkg::ST_IDLE : ffha_pkg::ST_DONE;
			default:            state_d = ffha_pkg::ST_IDLE;
		endcase
	end

	// memory access per state
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ffha_pkg::ST_A_RD, ffha_pkg::ST_R_RD, ffha_pkg::ST_M_RDA: begin
				mem_req.en   = 1'b1;
				mem_req.addr = h_q;
			end
			ffha_pkg::ST_A_WR1: begin
				mem_req.en    = 1'b1;
				mem_req.we    = 1'b1;
				mem_req.addr  = h_q;
				mem_req.wdata = '{free: 1'b0, size: wsize_q};
			end
			ffha_pkg::ST_A_WR2: begin
				mem_req.en    = 1'b1;
				mem_req.we    = 1'b1;
				mem_req.addr  = r_q;
				mem_req.wdata = '{free: 1'b1, size: rest_q};
			end
			ffha_pkg::ST_R_MOD: begin
				mem_req.en    = 1'b1;
				mem_req.we    = 1'b1;
				mem_req.addr  = h_q;
				mem_req.wdata = '{free: 1'b1, size: rd_data.size};
			end
			ffha_pkg::ST_M_RDB: begin
				mem_req.en   = 1'b1;
				mem_req.addr = b_q;
			end
			ffha_pkg::ST_M_CHK: begin
				if (do_merge) begin
					mem_req.en    = 1'b1;
					mem_req.we    = 1'b1;
					mem_req.addr  = h_q;
					mem_req.wdata = '{free: 1'b1, size: SW'(merged)};
				end
			end
			ffha_pkg::ST_IDLE, ffha_pkg::ST_A_CHK, ffha_pkg::ST_M_LDA,
			ffha_pkg::ST_DONE: begin
				mem_req = '0;
			end
			default: mem_req = '0;
		endcase
	end

	assign req.ready = (state_q == ffha_pkg::ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// walk and split registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ffha_pkg::ST_IDLE: begin
				if (accept) begin
					want_q        <= req.request_size;
					h_q           <= (req.kind == ffha_pkg::KIND_RELEASE) ? AW'(rel_h) : '0;
					res_granted_q <= 1'b0;
					res_off_q     <= '0;
				end
			end
			ffha_pkg::ST_A_CHK: begin
				if (fit) begin
					split_q       <= split;
					wsize_q       <= split ? SW'(want_q) : rd_data.size;
					rest_q        <= SW'(diff - HDR_N);
					r_q           <= AW'(r_sum);
					r_ok_q        <= r_sum < HEAP_N;
					res_granted_q <= 1'b1;
					res_off_q     <= OW'(NW'(h_q) + HDR_N);
				end else begin
					h_q <= AW'(nxt);
				end
			end
			ffha_pkg::ST_R_MOD: begin
				h_q           <= '0;
				res_granted_q <= 1'b1;
				res_off_q     <= '0;
			end
			ffha_pkg::ST_M_LDA: begin
				asize_q <= rd_data.size;
				afree_q <= rd_data.free;
				b_q     <= AW'(nxt);
			end
			ffha_pkg::ST_M_CHK: begin
				if (do_merge) begin
					asize_q <= SW'(merged);
				end else begin
					h_q     <= b_q;
					asize_q <= rd_data.size;
					afree_q <= rd_data.free;
				end
				b_q <= AW'(nxt);
			end
			ffha_pkg::ST_A_RD, ffha_pkg::ST_A_WR1, ffha_pkg::ST_A_WR2,
			ffha_pkg::ST_R_RD, ffha_pkg::ST_M_RDA, ffha_pkg::ST_M_RDB,
			ffha_pkg::ST_DONE: begin
				h_q <= h_q;
			end
			default: h_q <= h_q;
		endcase
	end

	// result register, valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ffha_pkg::ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register, payload
	always_ff @(posedge clk) begin
		if ((state_q == ffha_pkg::ST_DONE) && out_free) begin
			out_granted_q <= res_granted_q;
			out_off_q     <= res_off_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.granted        = out_granted_q;
	assign rsp.payload_offset = out_off_q;

endmodule

`default_nettype wire

[hdl/first_fit_heap_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over an implicit list of block headers kept in one
// single-port header memory.
//
//  channel  dir  fields                                   handshake
//  req      in   kind, request_size, release_offset       valid/ready
//  rsp      out  granted, payload_offset                  valid/ready
//
// Allocate: each header visited costs one memory read and one check state
// on the single memory port.
// Release: mostly the merge sweep over the headers in the chain.
// One request is in flight at a time; a new request is taken while the last
// result still waits in the output register.
// Reset clears control state only; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_core (
	input  wire        clk,
	input  wire        arst_n,
	ffha_req_if.sink   req,
	ffha_rsp_if.source rsp
);

	ffha_pkg::mem_req_t mem_req;
	ffha_pkg::hdr_t     rd_data;

	// header store
	ffha_hdr_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	// sequencer and result register
	ffha_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire
